FILE: rtl/band_peak_ratio_meter_macros.svh
// Assertion helpers shared by the meter's modules.
`ifndef BAND_PEAK_RATIO_METER_MACROS_SVH
`define BAND_PEAK_RATIO_METER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BRM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/brm_pkg.sv
`timescale 1ns / 1ps

package brm_pkg;

  // Default values for the top level parameters.
  localparam int MAX_BINS_DEF     = 1024;
  localparam int DB_FRAC_BITS_DEF = 8;

  // Field widths.
  localparam int MAG_W      = 32;
  localparam int BAND_W     = 11;
  localparam int ZC_W       = 11;
  localparam int RATIO_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BAND_END     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BAND_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATIO        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CROSS_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_STEP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_STEP        = 3'd5;

  // Configuration reset values.
  localparam logic [BAND_W-1:0]  RST_LOW_BAND_END     = 11'd46;
  localparam logic [BAND_W-1:0]  RST_HIGH_BAND_END    = 11'd93;
  localparam logic [RATIO_W-1:0] RST_MAX_RATIO        = 14'd11520;
  localparam logic [ZC_W-1:0]    RST_ZERO_CROSS_LIMIT = 11'd40;
  localparam logic [RATIO_W-1:0] RST_RISE_STEP        = 14'd256;
  localparam logic [RATIO_W-1:0] RST_FALL_STEP        = 14'd768;

  // round(20*log10(2) * 2^16), the dB weight of one octave in Q16.
  localparam int             DB_K_W = 19;
  localparam logic [DB_K_W-1:0] DB_K = 19'd394566;

  // Frame queue between the bin front end and the dB back end.
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = 2;

  typedef struct packed {
    logic [BAND_W-1:0]  low_band_end;
    logic [BAND_W-1:0]  high_band_end;
    logic [RATIO_W-1:0] max_ratio;
    logic [ZC_W-1:0]    zero_cross_limit;
    logic [RATIO_W-1:0] rise_step;
    logic [RATIO_W-1:0] fall_step;
  } cfg_t;

  typedef struct packed {
    logic [MAG_W-1:0] low_peak;
    logic [MAG_W-1:0] high_peak;
    logic             unvoiced;
  } frame_t;

endpackage

FILE: rtl/brm_fifo.sv
`timescale 1ns / 1ps
`include "band_peak_ratio_meter_macros.svh"

module brm_fifo
  import brm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t din,
  output logic   full,
  input  logic   pop,
  output frame_t dout,
  output logic   empty
);

  frame_t             mem_r [FQ_DEPTH];
  frame_t             dout_r;
  logic [FQ_AW-1:0]   wr_ptr_r;
  logic [FQ_AW-1:0]   rd_ptr_r;
  logic [FQ_AW:0]     count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == (FQ_AW+1)'(FQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = dout_r;

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Frame storage; a popped entry appears on dout the cycle after its pop.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
    if (do_pop) begin
      dout_r <= mem_r[rd_ptr_r];
    end
  end

  `BRM_ASSERT_IMPL(a_fq_count_bound, clk, rst_n, 1'b1, count_r <= (FQ_AW+1)'(FQ_DEPTH), "frame queue overfilled")

endmodule

FILE: rtl/brm_log.sv
`timescale 1ns / 1ps
`include "band_peak_ratio_meter_macros.svh"

// Converts a Q16.16 magnitude to dB: leading-one search in five halving
// steps, sixteen squaring steps for the log2 fraction, then one scaling
// multiply and a rounding step.
module brm_log
  import brm_pkg::*;
#(
  parameter int DB_FRAC_BITS = DB_FRAC_BITS_DEF,
  parameter int DBW          = DB_FRAC_BITS + 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MAG_W-1:0]      mag,
  output logic                  done,
  output logic signed [DBW-1:0] db
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQR  = 3'd2;
  localparam logic [2:0] L_MUL  = 3'd3;
  localparam logic [2:0] L_RAW  = 3'd4;

  localparam int         PROD_W   = 21 + DB_K_W;
  localparam int         SHR      = 32 - DB_FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF  = PROD_W'(1) << (SHR - 1);
  localparam logic [PROD_W-1:0] RAW16 =
    ((PROD_W'(16) << 16) * PROD_W'(DB_K) + HALF) >> SHR;
  localparam logic signed [DBW-1:0] DB_FLOOR = DBW'(-(100 << DB_FRAC_BITS));

  logic [2:0]            state_r;
  logic [3:0]            cnt_r;
  logic                  done_r;
  logic [MAG_W-1:0]      y_r;
  logic [4:0]            e_r;
  logic [15:0]           frac_r;
  logic                  zero_r;
  logic [PROD_W-1:0]     prod_r;
  logic signed [DBW-1:0] db_r;

  logic [4:0]            sh;
  logic                  top_zero;
  logic [63:0]           sq;
  logic [32:0]           sq_sh;
  logic [PROD_W-1:0]     raw;
  logic signed [DBW-1:0] db_nxt;

  // Halving search: the step width goes 16, 8, 4, 2, 1.
  assign sh       = 5'd16 >> cnt_r[2:0];
  assign top_zero = ((y_r >> (6'd32 - {1'b0, sh})) == '0);

  // One squaring step of the fractional log2.
  assign sq    = y_r * y_r;
  assign sq_sh = sq[63:31];

  // Round and rebase to a gain of one.
  assign raw    = (prod_r + HALF) >> SHR;
  assign db_nxt = $signed(raw[DBW-1:0]) - $signed(RAW16[DBW-1:0]);

  assign done = done_r;
  assign db   = db_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (start) begin
            cnt_r   <= '0;
            state_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (cnt_r == 4'd4) begin
            cnt_r   <= '0;
            state_r <= L_SQR;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        L_SQR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'd15) begin
            state_r <= L_MUL;
          end
        end
        L_MUL: begin
          state_r <= L_RAW;
        end
        L_RAW: begin
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: begin
          state_r <= L_IDLE;
        end
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (start) begin
          y_r    <= mag;
          e_r    <= 5'd31;
          frac_r <= '0;
          zero_r <= (mag == '0);
        end
      end
      L_NORM: begin
        if (top_zero) begin
          y_r <= y_r << sh;
          e_r <= e_r - sh;
        end
      end
      L_SQR: begin
        frac_r <= {frac_r[14:0], sq_sh[32]};
        y_r    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
      end
      L_MUL: begin
        prod_r <= {e_r, frac_r} * DB_K;
      end
      L_RAW: begin
        db_r <= zero_r ? DB_FLOOR : db_nxt;
      end
      default: begin
      end
    endcase
  end

  `BRM_ASSERT_IMPL(a_log_start_idle, clk, rst_n, start, state_r == L_IDLE, "log start while busy")
  `BRM_ASSERT_NEXT(a_log_raw_done, clk, rst_n, state_r == L_RAW, done_r && state_r == L_IDLE, "log result not flagged")

endmodule

FILE: rtl/brm_front.sv
`timescale 1ns / 1ps

// Bin front end: tracks the two band peaks one bin per cycle while the queue
// is not full, and hands a frame record to the queue on the last bin.
module brm_front
  import brm_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             push,
  input  logic             fifo_full,
  input  logic [MAG_W-1:0] bin_magnitude,
  input  logic             last_bin,
  input  logic [ZC_W-1:0]  zero_crossings,
  input  logic             weak_correlation,
  output logic             fifo_push,
  output frame_t           frame
);

  localparam int CNTW = $clog2(MAX_BINS + 1);
  localparam int CMPW = (CNTW > BAND_W) ? CNTW : BAND_W;

  logic [CNTW-1:0]  bin_count_r;
  logic [MAG_W-1:0] low_peak_r;
  logic [MAG_W-1:0] high_peak_r;

  logic             accept;
  logic             in_range;
  logic             in_low;
  logic             in_high;
  logic [MAG_W-1:0] low_peak_nxt;
  logic [MAG_W-1:0] high_peak_nxt;

  assign accept   = push && !fifo_full;
  assign in_range = (bin_count_r < CNTW'(MAX_BINS));
  assign in_low   = in_range && (CMPW'(bin_count_r) < CMPW'(cfg.low_band_end));
  assign in_high  = in_range && !in_low &&
                    (CMPW'(bin_count_r) < CMPW'(cfg.high_band_end));

  // Peak update for the current bin.
  assign low_peak_nxt  = (in_low && bin_magnitude > low_peak_r) ? bin_magnitude
                                                                  : low_peak_r;
  assign high_peak_nxt = (in_high && bin_magnitude > high_peak_r) ? bin_magnitude
                                                                    : high_peak_r;

  // Frame record, including the last bin itself.
  assign fifo_push       = accept && last_bin;
  assign frame.low_peak  = low_peak_nxt;
  assign frame.high_peak = high_peak_nxt;
  assign frame.unvoiced  = ((zero_crossings >= cfg.zero_cross_limit) &&
                            (zero_crossings != '0)) || weak_correlation;

  // Bin counter and running peaks, cleared at each frame end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= '0;
      low_peak_r  <= '0;
      high_peak_r <= '0;
    end else if (accept) begin
      if (last_bin) begin
        bin_count_r <= '0;
        low_peak_r  <= '0;
        high_peak_r <= '0;
      end else begin
        low_peak_r  <= low_peak_nxt;
        high_peak_r <= high_peak_nxt;
        if (in_range) begin
          bin_count_r <= bin_count_r + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/brm_back.sv
`timescale 1ns / 1ps
`include "band_peak_ratio_meter_macros.svh"

// Frame back end: reads one frame from the queue, converts both peaks with
// one shared dB unit, then clamps, applies the unvoiced override and
// slew-limits against the last frame.
module brm_back
  import brm_pkg::*;
#(
  parameter int DB_FRAC_BITS = DB_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               fifo_empty,
  input  frame_t             fifo_head,
  output logic               fifo_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [RATIO_W-1:0] out_ratio_db,
  output logic               out_unvoiced
);

  localparam int DBW = DB_FRAC_BITS + 11;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_LOW   = 3'd1;
  localparam logic [2:0] B_HIGH  = 3'd2;
  localparam logic [2:0] B_CLAMP = 3'd3;
  localparam logic [2:0] B_SLEW  = 3'd4;
  localparam logic [2:0] B_LOAD  = 3'd5;

  logic [2:0]            state_r;
  frame_t                frame_r;
  logic signed [DBW-1:0] db_low_r;
  logic signed [DBW-1:0] diff_r;
  logic [RATIO_W-1:0]    ratio_r;
  logic [RATIO_W-1:0]    prev_ratio_r;
  logic                  out_valid_r;
  logic [RATIO_W-1:0]    out_ratio_r;
  logic                  out_unv_r;

  logic                  log_start;
  logic [MAG_W-1:0]      log_mag;
  logic                  log_done;
  logic signed [DBW-1:0] log_db;

  logic signed [DBW-1:0] max_ext;
  logic [RATIO_W-1:0]    clamped;
  logic [RATIO_W-1:0]    ratio_nxt;
  logic [RATIO_W:0]      up_lim;
  logic [RATIO_W-1:0]    r_rise;
  logic [RATIO_W:0]      dn_sum;
  logic [RATIO_W-1:0]    r_slew;
  logic                  out_free;
  logic                  out_load;

  // Queue read, then the shared dB unit: low peak first, then high peak.
  assign fifo_pop  = (state_r == B_IDLE) && !fifo_empty;
  assign log_start = (state_r == B_LOAD) || ((state_r == B_LOW) && log_done);
  assign log_mag   = (state_r == B_LOAD) ? fifo_head.low_peak : frame_r.high_peak;

  brm_log #(
    .DB_FRAC_BITS (DB_FRAC_BITS),
    .DBW          (DBW)
  ) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .mag   (log_mag),
    .done  (log_done),
    .db    (log_db)
  );

  // Clamp to 0..max_ratio and apply the unvoiced override.
  assign max_ext = $signed({{(DBW-RATIO_W){1'b0}}, cfg.max_ratio});
  assign clamped = (diff_r < 0)       ? '0 :
                   (diff_r > max_ext) ? cfg.max_ratio : diff_r[RATIO_W-1:0];
  assign ratio_nxt = frame_r.unvoiced ? cfg.max_ratio : clamped;

  // Slew limit against the previous frame.
  assign up_lim = {1'b0, prev_ratio_r} + {1'b0, cfg.rise_step};
  assign r_rise = (up_lim < {1'b0, ratio_r}) ? up_lim[RATIO_W-1:0] : ratio_r;
  assign dn_sum = {1'b0, r_rise} + {1'b0, cfg.fall_step};
  assign r_slew = ({1'b0, prev_ratio_r} > dn_sum) ? (prev_ratio_r - cfg.fall_step)
                                                  : r_rise;

  // Output register transfer.
  assign out_free     = !out_valid_r || out_pop;
  assign out_load     = (state_r == B_SLEW) && out_free;
  assign out_empty    = !out_valid_r;
  assign out_ratio_db = out_ratio_r;
  assign out_unvoiced = out_unv_r;

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      prev_ratio_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!fifo_empty) begin
            state_r <= B_LOAD;
          end
        end
        B_LOAD: begin
          state_r <= B_LOW;
        end
        B_LOW: begin
          if (log_done) begin
            state_r <= B_HIGH;
          end
        end
        B_HIGH: begin
          if (log_done) begin
            state_r <= B_CLAMP;
          end
        end
        B_CLAMP: begin
          state_r <= B_SLEW;
        end
        B_SLEW: begin
          if (out_free) begin
            prev_ratio_r <= r_slew;
            state_r      <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == B_LOAD) begin
      frame_r <= fifo_head;
    end
    if ((state_r == B_LOW) && log_done) begin
      db_low_r <= log_db;
    end
    if ((state_r == B_HIGH) && log_done) begin
      diff_r <= db_low_r - log_db;
    end
    if (state_r == B_CLAMP) begin
      ratio_r <= ratio_nxt;
    end
    if (out_load) begin
      out_ratio_r <= r_slew;
      out_unv_r   <= frame_r.unvoiced;
    end
  end

  `BRM_ASSERT_IMPL(a_back_done_waiting, clk, rst_n, log_done, state_r == B_LOW || state_r == B_HIGH, "dB result outside a wait state")

endmodule

FILE: rtl/band_peak_ratio_meter.sv
`timescale 1ns / 1ps
// Result path: after its last bin transfers, a frame passes a queue read, two
// dB conversions on one shared log2 unit, clamp and slew.
// Throughput: one bin per cycle while in_full is low; frames are converted one
// at a time by the log2 unit; a four-frame queue absorbs short-frame bursts.
// Reset: synchronous, active low; restores register defaults and clears the
// bin counter, peaks, previous ratio and queues. No clearing pass.
module band_peak_ratio_meter
  import brm_pkg::*;
#(
  parameter int MAX_BINS     = MAX_BINS_DEF,
  parameter int DB_FRAC_BITS = DB_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [MAG_W-1:0]      in_bin_magnitude,
  input  logic                  in_last_bin,
  input  logic [ZC_W-1:0]       in_zero_crossings,
  input  logic                  in_weak_correlation,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [RATIO_W-1:0]    out_ratio_db,
  output logic                  out_unvoiced,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  logic   fq_push;
  logic   fq_full;
  logic   fq_pop;
  logic   fq_empty;
  frame_t fq_din;
  frame_t fq_dout;

  assign cfg_ready = 1'b1;
  assign in_full   = fq_full;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_band_end     <= RST_LOW_BAND_END;
      cfg_r.high_band_end    <= RST_HIGH_BAND_END;
      cfg_r.max_ratio        <= RST_MAX_RATIO;
      cfg_r.zero_cross_limit <= RST_ZERO_CROSS_LIMIT;
      cfg_r.rise_step        <= RST_RISE_STEP;
      cfg_r.fall_step        <= RST_FALL_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOW_BAND_END:     cfg_r.low_band_end     <= cfg_data[BAND_W-1:0];
        CFG_HIGH_BAND_END:    cfg_r.high_band_end    <= cfg_data[BAND_W-1:0];
        CFG_MAX_RATIO:        cfg_r.max_ratio        <= cfg_data[RATIO_W-1:0];
        CFG_ZERO_CROSS_LIMIT: cfg_r.zero_cross_limit <= cfg_data[ZC_W-1:0];
        CFG_RISE_STEP:        cfg_r.rise_step        <= cfg_data[RATIO_W-1:0];
        CFG_FALL_STEP:        cfg_r.fall_step        <= cfg_data[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Bin front end.
  brm_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .push             (in_push),
    .fifo_full        (fq_full),
    .bin_magnitude    (in_bin_magnitude),
    .last_bin         (in_last_bin),
    .zero_crossings   (in_zero_crossings),
    .weak_correlation (in_weak_correlation),
    .fifo_push        (fq_push),
    .frame            (fq_din)
  );

  // Frame queue.
  brm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   (fq_din),
    .full  (fq_full),
    .pop   (fq_pop),
    .dout  (fq_dout),
    .empty (fq_empty)
  );

  // dB back end with the output register.
  brm_back #(
    .DB_FRAC_BITS (DB_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .fifo_empty   (fq_empty),
    .fifo_head    (fq_dout),
    .fifo_pop     (fq_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_ratio_db (out_ratio_db),
    .out_unvoiced (out_unvoiced)
  );

endmodule
